// ----- sv/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, register indexes and the side-band word type for the swept
// circle collision pipeline.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RADIUS_BITS = 10;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_RADIUS = 1'b1;

  localparam int RR_W   = RADIUS_BITS + 1;           // sum of radii
  localparam int RSQ_W  = 2 * RR_W;                  // (r1+r2)^2
  localparam int P_W    = COORD_BITS + 1;            // start - center
  localparam int PV_W   = 2 * COORD_BITS + 1;        // p*v term, signed
  localparam int VV_W   = 2 * COORD_BITS;            // v*v term
  localparam int PP_W   = 2 * COORD_BITS + 1;        // p*p term
  localparam int A_W    = 2 * COORD_BITS;            // a = v.v
  localparam int B_W    = 2 * COORD_BITS + 2;        // b = p.v, signed
  localparam int C_W    = (2 * COORD_BITS + 3 > RSQ_W + 1) ?
                          2 * COORD_BITS + 3 : RSQ_W + 1;  // c, signed
  localparam int CU_W   = C_W - 1;                   // c when non-negative
  localparam int T_W    = C_W + 2;                   // condition sums
  localparam int MB_W   = 2 * COORD_BITS + 1;        // -b
  localparam int BB_W   = 2 * MB_W;
  localparam int AC_W   = A_W + CU_W;
  localparam int PW_W   = (BB_W > AC_W) ? BB_W : AC_W;
  localparam int D_W    = BB_W;                      // discriminant
  localparam int SQ_N   = (D_W + 2 * FRAC_BITS + 1) / 2;  // root bits / steps
  localparam int RAD_W  = 2 * SQ_N;
  localparam int REM_W  = SQ_N + 2;
  localparam int NUM_W  = MB_W + FRAC_BITS + 2;
  localparam int QS_N   = FRAC_BITS + 2;             // quotient bits / steps
  localparam int DV_W   = A_W + 1 + QS_N;
  localparam int CMP_W  = (NUM_W > DV_W) ? NUM_W : DV_W;
  localparam int MX_W   = COORD_BITS + FRAC_BITS + 2;
  localparam int OUT_W  = COORD_BITS + 1;

  typedef struct packed {
    logic                         ok;
    logic                         big;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic        [A_W-1:0]        a;
    logic        [MB_W-1:0]       mb;
  } scc_side_t;

endpackage

// ----- sv/scc_isqrt.sv -----
// ----------------------------------------------------------------------------
// scc_isqrt
// Pipelined floor square root of d * 2^(2*FRAC_BITS), one root bit per stage.
// ----------------------------------------------------------------------------
module scc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [scc_pkg::D_W-1:0]     in_d,
  input  scc_pkg::scc_side_t          in_side,
  output logic                        out_vld,
  output logic [scc_pkg::SQ_N-1:0]    out_root,
  output scc_pkg::scc_side_t          out_side
);

  localparam int N  = scc_pkg::SQ_N;
  localparam int RW = scc_pkg::REM_W;
  localparam int DW = scc_pkg::RAD_W;

  logic                vld_r  [N];
  logic [RW-1:0]       rem_r  [N];
  logic [N-1:0]        root_r [N];
  logic [DW-1:0]       rad_r  [N];
  scc_pkg::scc_side_t  side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic                vld_i;
    logic [RW-1:0]       rem_i;
    logic [N-1:0]        root_i;
    logic [DW-1:0]       rad_i;
    scc_pkg::scc_side_t  side_i;
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = DW'(in_d) << (2 * scc_pkg::FRAC_BITS);
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_i[RW-3:0], rad_i[DW-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_i[N-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_i[N-2:0], 1'b0};
        end
        rad_r[k]  <= rad_i << 2;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ----- sv/scc_div.sv -----
// ----------------------------------------------------------------------------
// scc_div
// Pipelined restoring divide of num by 2*a, one quotient bit per stage.
// ----------------------------------------------------------------------------
module scc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [scc_pkg::NUM_W-1:0]   in_num,
  input  scc_pkg::scc_side_t          in_side,
  output logic                        out_vld,
  output logic [scc_pkg::QS_N-1:0]    out_q,
  output scc_pkg::scc_side_t          out_side
);

  localparam int N  = scc_pkg::QS_N;
  localparam int CW = scc_pkg::CMP_W;

  logic                vld_r  [N];
  logic [CW-1:0]       rem_r  [N];
  logic [N-1:0]        q_r    [N];
  scc_pkg::scc_side_t  side_r [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    logic                vld_i;
    logic [CW-1:0]       rem_i;
    logic [N-1:0]        q_i;
    scc_pkg::scc_side_t  side_i;
    logic [CW-1:0]       dsh;

    if (j == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = CW'(in_num);
      assign q_i    = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign q_i    = q_r[j-1];
      assign side_i = side_r[j-1];
    end

    assign dsh = CW'({side_i.a, 1'b0}) << (N - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= dsh) begin
          rem_r[j] <= rem_i - dsh;
          q_r[j]   <= {q_i[N-2:0], 1'b1};
        end else begin
          rem_r[j] <= rem_i;
          q_r[j]   <= {q_i[N-2:0], 1'b0};
        end
        side_r[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_q    = q_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ----- sv/swept_circle_collision_unit.sv -----
// ----------------------------------------------------------------------------
// swept_circle_collision_unit
// Time of first contact of a moving circle against a static circle, with the
// contact centre, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The pipe has 6 setup stages, one stage per root bit in the square root, one
// per quotient bit in the divide, then 4 finishing stages. Throughput: one
// word per cycle; the whole pipe holds while the output word is stalled.
// Synchronous reset clears the valid bits and loads the radii with 20 and 1.
// ----------------------------------------------------------------------------
module swept_circle_collision_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scc_pkg::RADIUS_BITS-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_motion_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_motion_y,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] in_center_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic [scc_pkg::FRAC_BITS:0]           out_fraction,
  output logic signed [scc_pkg::OUT_W-1:0]      out_contact_x,
  output logic signed [scc_pkg::OUT_W-1:0]      out_contact_y
);

  localparam int CB = scc_pkg::COORD_BITS;
  localparam int FB = scc_pkg::FRAC_BITS;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // configuration
  logic [scc_pkg::RADIUS_BITS-1:0] moving_radius_r, static_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_radius_r <= scc_pkg::RADIUS_BITS'(20);
      static_radius_r <= scc_pkg::RADIUS_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::REG_MOVING_RADIUS: moving_radius_r <= cfg_wdata;
        scc_pkg::REG_STATIC_RADIUS: static_radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: relative position, radius sum
  logic                          s1_vld_r;
  logic signed [CB-1:0]          s1_sx_r, s1_sy_r, s1_vx_r, s1_vy_r;
  logic signed [scc_pkg::P_W-1:0] s1_px_r, s1_py_r;
  logic [scc_pkg::RR_W-1:0]      s1_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r <= in_start_x;
      s1_sy_r <= in_start_y;
      s1_vx_r <= in_motion_x;
      s1_vy_r <= in_motion_y;
      s1_px_r <= scc_pkg::P_W'(in_start_x) - scc_pkg::P_W'(in_center_x);
      s1_py_r <= scc_pkg::P_W'(in_start_y) - scc_pkg::P_W'(in_center_y);
      s1_rr_r <= scc_pkg::RR_W'(moving_radius_r) + scc_pkg::RR_W'(static_radius_r);
    end
  end

  // stage 2: products
  logic                            s2_vld_r;
  logic signed [CB-1:0]            s2_sx_r, s2_sy_r, s2_vx_r, s2_vy_r;
  logic signed [scc_pkg::PV_W-1:0] s2_pvx_r, s2_pvy_r;
  logic [scc_pkg::VV_W-1:0]        s2_vxx_r, s2_vyy_r;
  logic [scc_pkg::PP_W-1:0]        s2_pxx_r, s2_pyy_r;
  logic [scc_pkg::RSQ_W-1:0]       s2_rsq_r;
  logic signed [scc_pkg::PP_W:0]   pxx_nxt, pyy_nxt;

  assign pxx_nxt = (scc_pkg::PP_W+1)'(s1_px_r) * (scc_pkg::PP_W+1)'(s1_px_r);
  assign pyy_nxt = (scc_pkg::PP_W+1)'(s1_py_r) * (scc_pkg::PP_W+1)'(s1_py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;
      s2_vx_r  <= s1_vx_r;
      s2_vy_r  <= s1_vy_r;
      s2_pvx_r <= scc_pkg::PV_W'(s1_px_r) * scc_pkg::PV_W'(s1_vx_r);
      s2_pvy_r <= scc_pkg::PV_W'(s1_py_r) * scc_pkg::PV_W'(s1_vy_r);
      s2_vxx_r <= scc_pkg::VV_W'(scc_pkg::VV_W'(s1_vx_r) * scc_pkg::VV_W'(s1_vx_r));
      s2_vyy_r <= scc_pkg::VV_W'(scc_pkg::VV_W'(s1_vy_r) * scc_pkg::VV_W'(s1_vy_r));
      s2_pxx_r <= scc_pkg::PP_W'(pxx_nxt);
      s2_pyy_r <= scc_pkg::PP_W'(pyy_nxt);
      s2_rsq_r <= scc_pkg::RSQ_W'(s1_rr_r) * scc_pkg::RSQ_W'(s1_rr_r);
    end
  end

  // stage 3: a, b, c
  logic                           s3_vld_r;
  logic signed [CB-1:0]           s3_sx_r, s3_sy_r, s3_vx_r, s3_vy_r;
  logic [scc_pkg::A_W-1:0]        s3_a_r;
  logic signed [scc_pkg::B_W-1:0] s3_b_r;
  logic signed [scc_pkg::C_W-1:0] s3_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sx_r <= s2_sx_r;
      s3_sy_r <= s2_sy_r;
      s3_vx_r <= s2_vx_r;
      s3_vy_r <= s2_vy_r;
      s3_a_r  <= scc_pkg::A_W'(s2_vxx_r) + scc_pkg::A_W'(s2_vyy_r);
      s3_b_r  <= scc_pkg::B_W'(s2_pvx_r) + scc_pkg::B_W'(s2_pvy_r);
      s3_c_r  <= $signed(scc_pkg::C_W'(s2_pxx_r)) + $signed(scc_pkg::C_W'(s2_pyy_r))
               - $signed(scc_pkg::C_W'(s2_rsq_r));
    end
  end

  // stage 4: early reject (zero motion, overlap at start, moving away,
  // smaller root beyond the step)
  logic                           s4_vld_r;
  scc_pkg::scc_side_t             s4_side_r;
  logic [scc_pkg::CU_W-1:0]       s4_cu_r;
  logic signed [scc_pkg::T_W-1:0] a_s, b_s, c_s, t1, t2;
  scc_pkg::scc_side_t             s4_side_nxt;

  always_comb begin
    a_s = scc_pkg::T_W'($signed({1'b0, s3_a_r}));
    b_s = scc_pkg::T_W'(s3_b_r);
    c_s = scc_pkg::T_W'(s3_c_r);
    t1  = a_s + b_s;
    t2  = a_s + (b_s <<< 1) + c_s;
    s4_side_nxt.ok  = (s3_a_r != '0) && !s3_c_r[scc_pkg::C_W-1] &&
                      (s3_b_r[scc_pkg::B_W-1] || s3_b_r == '0) &&
                      (!t1[scc_pkg::T_W-1] || t2[scc_pkg::T_W-1] || t2 == '0);
    s4_side_nxt.big = 1'b0;
    s4_side_nxt.sx  = s3_sx_r;
    s4_side_nxt.sy  = s3_sy_r;
    s4_side_nxt.vx  = s3_vx_r;
    s4_side_nxt.vy  = s3_vy_r;
    s4_side_nxt.a   = s3_a_r;
    s4_side_nxt.mb  = scc_pkg::MB_W'(-b_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s4_side_nxt;
      s4_cu_r   <= scc_pkg::CU_W'(s3_c_r);
    end
  end

  // stage 5: b^2 and a*c
  logic                     s5_vld_r;
  scc_pkg::scc_side_t       s5_side_r;
  logic [scc_pkg::BB_W-1:0] s5_bb_r;
  logic [scc_pkg::AC_W-1:0] s5_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (en) s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_bb_r   <= scc_pkg::BB_W'(s4_side_r.mb) * scc_pkg::BB_W'(s4_side_r.mb);
      s5_ac_r   <= scc_pkg::AC_W'(s4_side_r.a) * scc_pkg::AC_W'(s4_cu_r);
    end
  end

  // stage 6: discriminant
  logic                     s6_vld_r;
  scc_pkg::scc_side_t       s6_side_r;
  logic [scc_pkg::D_W-1:0]  s6_d_r;
  logic [scc_pkg::PW_W-1:0] bb_w, ac_w;
  scc_pkg::scc_side_t       s6_side_nxt;

  assign bb_w = scc_pkg::PW_W'(s5_bb_r);
  assign ac_w = scc_pkg::PW_W'(s5_ac_r);

  always_comb begin
    s6_side_nxt    = s5_side_r;
    s6_side_nxt.ok = s5_side_r.ok && (ac_w <= bb_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (en) s6_vld_r <= s5_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s6_side_nxt;
      s6_d_r    <= scc_pkg::D_W'(bb_w - ac_w);
    end
  end

  // square root
  logic                     sq_vld;
  logic [scc_pkg::SQ_N-1:0] sq_root;
  scc_pkg::scc_side_t       sq_side;

  scc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s6_vld_r),
    .in_d     (s6_d_r),
    .in_side  (s6_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // numerator 2*(-b*2^F - s) + a, plus quotient overflow check
  logic                      n_vld_r;
  scc_pkg::scc_side_t        n_side_r;
  logic [scc_pkg::NUM_W-1:0] n_num_r;
  logic [scc_pkg::NUM_W-1:0] num_nxt;
  scc_pkg::scc_side_t        n_side_nxt;

  assign num_nxt = (((scc_pkg::NUM_W'(sq_side.mb) << FB) - scc_pkg::NUM_W'(sq_root)) << 1)
                 + scc_pkg::NUM_W'(sq_side.a);

  always_comb begin
    n_side_nxt     = sq_side;
    n_side_nxt.big = scc_pkg::CMP_W'(num_nxt) >=
                     (scc_pkg::CMP_W'(sq_side.a) << (scc_pkg::QS_N + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (en) n_vld_r <= sq_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_side_r <= n_side_nxt;
      n_num_r  <= num_nxt;
    end
  end

  // divide
  logic                     dv_vld;
  logic [scc_pkg::QS_N-1:0] dv_q;
  scc_pkg::scc_side_t       dv_side;

  scc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (n_vld_r),
    .in_num   (n_num_r),
    .in_side  (n_side_r),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // fraction clamp
  logic                 f_vld_r, f_hit_r;
  logic [FB:0]          f_frac_r;
  logic signed [CB-1:0] f_sx_r, f_sy_r, f_vx_r, f_vy_r;
  logic [FB:0]          frac_nxt;

  always_comb begin
    if (!dv_side.ok) begin
      frac_nxt = '0;
    end else if (dv_side.big || dv_q > (scc_pkg::QS_N'(1) << FB)) begin
      frac_nxt = (FB+1)'(1) << FB;
    end else begin
      frac_nxt = dv_q[FB:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_hit_r  <= dv_side.ok;
      f_frac_r <= frac_nxt;
      f_sx_r   <= dv_side.sx;
      f_sy_r   <= dv_side.sy;
      f_vx_r   <= dv_side.vx;
      f_vy_r   <= dv_side.vy;
    end
  end

  // motion * fraction
  logic                             m_vld_r, m_hit_r;
  logic [FB:0]                      m_frac_r;
  logic signed [CB-1:0]             m_sx_r, m_sy_r;
  logic signed [scc_pkg::MX_W-1:0]  m_mx_r, m_my_r;
  logic signed [scc_pkg::MX_W-1:0]  frac_s;

  assign frac_s = scc_pkg::MX_W'($signed({1'b0, f_frac_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (en) m_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit_r  <= f_hit_r;
      m_frac_r <= f_frac_r;
      m_sx_r   <= f_sx_r;
      m_sy_r   <= f_sy_r;
      m_mx_r   <= scc_pkg::MX_W'(f_vx_r) * frac_s;
      m_my_r   <= scc_pkg::MX_W'(f_vy_r) * frac_s;
    end
  end

  // round half up (floor after adding one half) and offset from start
  logic signed [scc_pkg::MX_W:0]    rx, ry;
  logic signed [scc_pkg::OUT_W-1:0] cx_nxt, cy_nxt;

  always_comb begin
    rx = (scc_pkg::MX_W+1)'(m_mx_r) + ((scc_pkg::MX_W+1)'(1) <<< (FB - 1));
    ry = (scc_pkg::MX_W+1)'(m_my_r) + ((scc_pkg::MX_W+1)'(1) <<< (FB - 1));
    cx_nxt = scc_pkg::OUT_W'(m_sx_r) + scc_pkg::OUT_W'(rx >>> FB);
    cy_nxt = scc_pkg::OUT_W'(m_sy_r) + scc_pkg::OUT_W'(ry >>> FB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit       <= m_hit_r;
      out_fraction  <= m_frac_r;
      out_contact_x <= m_hit_r ? cx_nxt : '0;
      out_contact_y <= m_hit_r ? cy_nxt : '0;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for swept_circle_collision_unit. A queue-fed driver
// sends collision queries, an in-bench predictor computes the time of impact
// and contact centre, and a monitor compares every result word in order.
// Covers several radius settings, directed corner cases and aimed random
// sweeps, with random idling and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [scc_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [scc_pkg::RADIUS_BITS-1:0] radius_t;

  typedef struct packed {
    coord_t sx, sy, vx, vy, cx, cy;
  } query_t;

  typedef struct packed {
    logic                           hit;
    logic [scc_pkg::FRAC_BITS:0]    fraction;
    logic [scc_pkg::OUT_W-1:0]      contact_x;
    logic [scc_pkg::OUT_W-1:0]      contact_y;
  } impact_t;

  localparam int PIPE_LAT = 77;

  logic clk, rst_n;
  logic cfg_we;
  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index;
  radius_t cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  coord_t in_start_x, in_start_y, in_motion_x, in_motion_y, in_center_x, in_center_y;
  logic out_hit;
  logic [scc_pkg::FRAC_BITS:0] out_fraction;
  logic signed [scc_pkg::OUT_W-1:0] out_contact_x, out_contact_y;

  query_t  query_q[$];
  impact_t impact_q[$];
  radius_t mov_rad, sta_rad;
  int idle_pct;
  int n_queued, n_sent, n_results, n_hits, n_errors;
  logic took;

  swept_circle_collision_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic impact_t predict_impact(query_t w, radius_t r1, radius_t r2);
    longint px, py, a, b, c, rr, ox, oy;
    logic [127:0] bb, ac, disc, num, cand;
    logic [63:0] root, q;
    impact_t r;
    int i;
    r = '0;
    px = longint'(w.sx) - longint'(w.cx);
    py = longint'(w.sy) - longint'(w.cy);
    a = longint'(w.vx) * w.vx + longint'(w.vy) * w.vy;
    b = px * w.vx + py * w.vy;
    rr = longint'(r1) + longint'(r2);
    c = px * px + py * py - rr * rr;
    if (a > 0 && c >= 0 && b <= 0 && ((a + b >= 0) || (a + 2 * b + c <= 0))) begin
      bb = 128'(-b) * 128'(-b);
      ac = 128'(a) * 128'(c);
      if (ac <= bb) begin
        disc = (bb - ac) << (2 * scc_pkg::FRAC_BITS);
        root = '0;
        for (i = 63; i >= 0; i--) begin
          cand = {64'b0, root | (64'b1 << i)};
          if (cand * cand <= disc) root = root | (64'b1 << i);
        end
        num = ((128'(-b) << scc_pkg::FRAC_BITS) - {64'b0, root}) * 2 + 128'(a);
        q = 64'(num / (128'(a) * 2));
        if (q > (64'b1 << scc_pkg::FRAC_BITS)) q = 64'b1 << scc_pkg::FRAC_BITS;
        // floor of (v*k + half) / 2^FRAC_BITS, i.e. round half up
        ox = longint'(w.sx) + ((longint'(w.vx) * longint'(q)
             + (1 << (scc_pkg::FRAC_BITS-1))) >>> scc_pkg::FRAC_BITS);
        oy = longint'(w.sy) + ((longint'(w.vy) * longint'(q)
             + (1 << (scc_pkg::FRAC_BITS-1))) >>> scc_pkg::FRAC_BITS);
        r.hit = 1'b1;
        r.fraction = q[scc_pkg::FRAC_BITS:0];
        r.contact_x = ox[scc_pkg::OUT_W-1:0];
        r.contact_y = oy[scc_pkg::OUT_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
  endtask

  // driver: new word at falling edge once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
      if (!in_valid || took) begin
        if (query_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          query_t w;
          w = query_q.pop_front();
          in_valid <= 1'b1;
          {in_start_x, in_start_y, in_motion_x, in_motion_y, in_center_x, in_center_y} <= w;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: accepted inputs feed the predictor, accepted outputs are checked
  always @(posedge clk) begin
    took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      impact_q.push_back(predict_impact({in_start_x, in_start_y, in_motion_x, in_motion_y,
                                         in_center_x, in_center_y}, mov_rad, sta_rad));
      n_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (impact_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        impact_t e;
        e = impact_q.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_fraction !== e.fraction) report_mismatch("fraction", out_fraction, e.fraction);
        if (out_contact_x !== e.contact_x)
          report_mismatch("contact_x", out_contact_x, $signed(e.contact_x));
        if (out_contact_y !== e.contact_y)
          report_mismatch("contact_y", out_contact_y, $signed(e.contact_y));
        if (e.hit) n_hits++;
      end
      n_results++;
    end
  end

  task automatic add_query(int sx, int sy, int vx, int vy, int cx, int cy);
    query_t w;
    w = {coord_t'(sx), coord_t'(sy), coord_t'(vx), coord_t'(vy), coord_t'(cx), coord_t'(cy)};
    query_q.push_back(w);
    n_queued++;
  endtask

  task automatic write_radius(logic [scc_pkg::CFG_IDX_W-1:0] idx, radius_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == scc_pkg::REG_MOVING_RADIUS) mov_rad = val;
    else sta_rad = val;
  endtask

  task automatic drain();
    while (n_sent != n_queued || impact_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic add_random(int count);
    int k, mode, cx, cy, dx, dy, m;
    for (k = 0; k < count; k++) begin
      mode = $urandom_range(0, 9);
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      dx = $urandom_range(0, 6000) - 3000;
      dy = $urandom_range(0, 6000) - 3000;
      m = $urandom_range(1, 8);
      if (mode < 6)        // aimed at the static circle, with jitter
        add_query(cx + dx, cy + dy, -dx * m / 4 + int'($urandom_range(0, 400)) - 200,
                  -dy * m / 4 + int'($urandom_range(0, 400)) - 200, cx, cy);
      else if (mode < 8)
        add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        add_query(cx + dx / 60, cy + dy / 60, dx / 30, dy / 30, cx, cy);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = scc_pkg::REG_MOVING_RADIUS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_start_x, in_start_y, in_motion_x, in_motion_y, in_center_x, in_center_y} = '0;
    mov_rad = radius_t'(20);
    sta_rad = radius_t'(1);
    idle_pct = 13;
    n_queued = 0; n_sent = 0; n_results = 0; n_hits = 0; n_errors = 0;
    took = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed, reset radii (sum 21)
    add_query(0, 0, 0, 0, 100, 0);               // zero motion
    add_query(0, 0, 100, 0, 10, 0);              // start overlapping
    add_query(0, 0, -100, 0, 100, 0);            // moving away
    add_query(0, 0, 100, 0, 50, 500);            // passes wide
    add_query(0, 0, 100, 0, 71, 0);              // contact at k = 0.5
    add_query(0, 0, 100, 0, 121, 0);             // contact at k = 1
    add_query(0, 0, 100, 0, 21, 0);              // touching at k = 0
    add_query(0, 0, 100, 0, 60, 21);             // grazing tangent
    add_query(0, 0, 100, 0, 122, 0);             // just beyond the step
    add_query(-32768, -32768, 32767, 32767, 32767, 32767);
    add_query(32767, 32767, -32768, -32768, -32768, -32768);
    add_query(-32768, 32767, -32768, 32767, 0, 0);
    add_query(-32768, 0, 32767, 0, -10, 3);
    add_query(32767, -32768, -32768, 32767, -1, -1);
    add_query(-1, -1, -32768, -32768, -32768, -32768);
    add_query(100, 100, -7, -3, 95, 97);
    add_random(150);
    drain();

    // both radii zero, no idling stretch
    write_radius(scc_pkg::REG_MOVING_RADIUS, radius_t'(0));
    write_radius(scc_pkg::REG_STATIC_RADIUS, radius_t'(0));
    idle_pct = 0;
    add_query(0, 0, 100, 0, 50, 0);
    add_query(0, 0, 100, 0, 50, 1);
    add_random(250);
    drain();
    idle_pct = 13;

    write_radius(scc_pkg::REG_MOVING_RADIUS, radius_t'(1023));
    write_radius(scc_pkg::REG_STATIC_RADIUS, radius_t'(1023));
    add_query(0, 0, 32767, 0, 3000, 0);
    add_query(0, 0, -32768, -32768, -3000, -2000);
    add_random(300);
    drain();

    write_radius(scc_pkg::REG_MOVING_RADIUS, radius_t'($urandom_range(1, 1022)));
    write_radius(scc_pkg::REG_STATIC_RADIUS, radius_t'($urandom_range(1, 1022)));
    add_random(300);
    drain();

    $display("Ran %0d queries over four radius settings; %0d results, %0d hits.",
             n_sent, n_results, n_hits);
    if (impact_q.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
